### hdl/mfrm_pkg.sv
// Shared constants and types for the multi-field range rule matcher.
// Holds operation codes, register indexes and the result record.
// No dependencies.
`default_nettype none

package mfrm_pkg;

   // Item operation codes.
   localparam logic OP_WRITE    = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   // Configuration register indexes and port widths.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RULES_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIMS_IN_USE  = 1'b1;

   localparam int RULES_CFG_BITS = 6;
   localparam int DIMS_CFG_BITS  = 3;
   localparam logic [RULES_CFG_BITS-1:0] RULES_CFG_RESET = 6'd32;
   localparam logic [DIMS_CFG_BITS-1:0]  DIMS_CFG_RESET  = 3'd4;

   // Fixed widths of the transaction fields.
   localparam int POINT_FIELDS  = 4;
   localparam int POINT_BITS    = 16;
   localparam int RULE_ID_BITS  = 5;
   localparam int DIM_ID_BITS   = 2;

   // One result transaction.
   typedef struct packed {
      logic [RULE_ID_BITS-1:0] matched_rule;
      logic                    no_match;
      logic                    overlap;
      logic                    last;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/multi_field_range_rule_match.sv
// Multi-field range rule matcher: top level with configuration registers.
// Depends on mfrm_pkg, mfrm_rule_table and mfrm_scan.
//
// Usage:
//   The req_ channel takes two kinds of transaction. A write (op = write)
//   stores one low/high bound pair for one rule and dimension and gives no
//   response. A classify (op = classify) carries a header point; the block
//   reads one rule row per cycle from the bound table while no match waits
//   on a stalled receiver, and compares every dimension in use in parallel.
//   Each matching rule is sent on the rsp_ channel in ascending order, the
//   final one marked last; overlap is set when two or more rules match,
//   and a single no_match transaction is sent when none match.
//   A classify holds req_stall high until its final response is loaded into
//   the output register; rules_in_use above the table size counts as the
//   table size. Writes are taken at one per cycle while no classify runs.
//   One match is held back until the next match or the end of the walk, so
//   the first response follows the compare of the second match, or the end
//   of the walk when only one rule matches.
//   When rsp_stall is high and a response is already waiting, the walk
//   pauses at the next match that must be sent; nothing is dropped.
//   Reset clears the control state and sets rules_in_use to 32 and
//   dims_in_use to 4; the bound table is undefined until written.
`default_nettype none

module multi_field_range_rule_match #(
   parameter int MAX_RULES  = 32,
   parameter int MAX_DIMS   = 4,
   parameter int FIELD_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Configuration write port.
   input  wire logic                                 csr_write,
   input  wire logic [mfrm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [mfrm_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   // Request channel.
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_op,
   input  wire logic [mfrm_pkg::RULE_ID_BITS-1:0]    req_rule_index,
   input  wire logic [mfrm_pkg::DIM_ID_BITS-1:0]     req_dim_index,
   input  wire logic [mfrm_pkg::POINT_BITS-1:0]      req_bound_low,
   input  wire logic [mfrm_pkg::POINT_BITS-1:0]      req_bound_high,
   input  wire logic [mfrm_pkg::POINT_BITS-1:0]      req_point_0,
   input  wire logic [mfrm_pkg::POINT_BITS-1:0]      req_point_1,
   input  wire logic [mfrm_pkg::POINT_BITS-1:0]      req_point_2,
   input  wire logic [mfrm_pkg::POINT_BITS-1:0]      req_point_3,
   // Response channel.
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [mfrm_pkg::RULE_ID_BITS-1:0]         rsp_matched_rule,
   output logic                                      rsp_no_match,
   output logic                                      rsp_overlap,
   output logic                                      rsp_last
);

   import mfrm_pkg::*;

   localparam int RULE_BITS = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int DIM_BITS  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   logic [RULES_CFG_BITS-1:0] rules_cfg_ff, rules_cfg_in;
   logic [DIMS_CFG_BITS-1:0]  dims_cfg_ff, dims_cfg_in;

   logic                  req_accept;
   logic                  wr_en;
   logic                  start;
   logic                  busy;
   logic [POINT_BITS-1:0] points [POINT_FIELDS];
   logic                  rd_en;
   logic [RULE_BITS-1:0]  rd_rule;
   logic [FIELD_BITS-1:0] rd_low  [MAX_DIMS];
   logic [FIELD_BITS-1:0] rd_high [MAX_DIMS];
   rsp_type               rsp_data;

   // Configuration register writes.
   always_comb begin
      rules_cfg_in = rules_cfg_ff;
      dims_cfg_in  = dims_cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_RULES_IN_USE: rules_cfg_in = csr_wdata[RULES_CFG_BITS-1:0];
            REG_DIMS_IN_USE:  dims_cfg_in  = csr_wdata[DIMS_CFG_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rules_cfg_ff <= RULES_CFG_RESET;
         dims_cfg_ff  <= DIMS_CFG_RESET;
      end else begin
         rules_cfg_ff <= rules_cfg_in;
         dims_cfg_ff  <= dims_cfg_in;
      end
   end

   // Request decode; writes outside the table are dropped.
   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && (req_op == OP_WRITE)
                       && (32'(req_rule_index) < MAX_RULES)
                       && (32'(req_dim_index) < MAX_DIMS);
   assign start      = req_accept && (req_op == OP_CLASSIFY);

   assign points[0] = req_point_0;
   assign points[1] = req_point_1;
   assign points[2] = req_point_2;
   assign points[3] = req_point_3;

   mfrm_rule_table #(
      .MAX_RULES  (MAX_RULES),
      .MAX_DIMS   (MAX_DIMS),
      .FIELD_BITS (FIELD_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_rule (RULE_BITS'(req_rule_index)),
      .wr_dim  (DIM_BITS'(req_dim_index)),
      .wr_low  (FIELD_BITS'(req_bound_low)),
      .wr_high (FIELD_BITS'(req_bound_high)),
      .rd_en   (rd_en),
      .rd_rule (rd_rule),
      .rd_low  (rd_low),
      .rd_high (rd_high)
   );

   mfrm_scan #(
      .MAX_RULES  (MAX_RULES),
      .MAX_DIMS   (MAX_DIMS),
      .FIELD_BITS (FIELD_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .start_points (points),
      .rules_cfg    (rules_cfg_ff),
      .dims_cfg     (dims_cfg_ff),
      .busy         (busy),
      .rd_en        (rd_en),
      .rd_rule      (rd_rule),
      .rd_low       (rd_low),
      .rd_high      (rd_high),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   assign rsp_matched_rule = rsp_data.matched_rule;
   assign rsp_no_match     = rsp_data.no_match;
   assign rsp_overlap      = rsp_data.overlap;
   assign rsp_last         = rsp_data.last;

endmodule

`default_nettype wire

### hdl/mfrm_rule_table.sv
// Rule bound storage: one row per rule, one low and one high bound per dimension.
// Synchronous write of one dimension, registered read of one whole row.
// No package dependencies.
`default_nettype none

module mfrm_rule_table #(
   parameter int MAX_RULES  = 32,
   parameter int MAX_DIMS   = 4,
   parameter int FIELD_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(MAX_RULES > 1 ? $clog2(MAX_RULES) : 1)-1:0] wr_rule,
   input  wire logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0]   wr_dim,
   input  wire logic [FIELD_BITS-1:0]                 wr_low,
   input  wire logic [FIELD_BITS-1:0]                 wr_high,
   input  wire logic                                  rd_en,
   input  wire logic [(MAX_RULES > 1 ? $clog2(MAX_RULES) : 1)-1:0] rd_rule,
   output logic      [FIELD_BITS-1:0]                 rd_low  [MAX_DIMS],
   output logic      [FIELD_BITS-1:0]                 rd_high [MAX_DIMS]
);

   logic [FIELD_BITS-1:0] low_mem  [MAX_RULES][MAX_DIMS];
   logic [FIELD_BITS-1:0] high_mem [MAX_RULES][MAX_DIMS];

   // Write one dimension of one rule.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         low_mem[wr_rule][wr_dim]  <= wr_low;
         high_mem[wr_rule][wr_dim] <= wr_high;
      end
   end

   // Read a whole rule row; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_low  <= low_mem[rd_rule];
         rd_high <= high_mem[rd_rule];
      end
   end

endmodule

`default_nettype wire

### hdl/mfrm_scan.sv
// Classify sequencer: walks the rule table one rule per cycle while the output
// does not stall, and emits matches. Holds one match back so that overlap and last
// are known when it is sent. Depends on mfrm_pkg.
`default_nettype none

module mfrm_scan #(
   parameter int MAX_RULES  = 32,
   parameter int MAX_DIMS   = 4,
   parameter int FIELD_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [mfrm_pkg::POINT_BITS-1:0]       start_points [mfrm_pkg::POINT_FIELDS],
   input  wire logic [mfrm_pkg::RULES_CFG_BITS-1:0]   rules_cfg,
   input  wire logic [mfrm_pkg::DIMS_CFG_BITS-1:0]    dims_cfg,
   output logic                                       busy,
   output logic                                       rd_en,
   output logic [(MAX_RULES > 1 ? $clog2(MAX_RULES) : 1)-1:0] rd_rule,
   input  wire logic [FIELD_BITS-1:0]                 rd_low  [MAX_DIMS],
   input  wire logic [FIELD_BITS-1:0]                 rd_high [MAX_DIMS],
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output mfrm_pkg::rsp_type                          rsp_data
);

   import mfrm_pkg::*;

   localparam int RULE_BITS  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int COUNT_BITS = $clog2(MAX_RULES + 1);
   localparam int CMP_DIMS   = (MAX_DIMS < POINT_FIELDS) ? MAX_DIMS : POINT_FIELDS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] nrules_ff, nrules_in;
   logic [COUNT_BITS-1:0] issue_ff, issue_in;
   logic [FIELD_BITS-1:0] pt_ff [CMP_DIMS];
   logic [CMP_DIMS-1:0]   dim_en_ff, dim_en_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [RULE_BITS-1:0]  cmp_rule_ff, cmp_rule_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [RULE_BITS-1:0]  pend_rule_ff, pend_rule_in;
   logic                  multi_ff, multi_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  rsp_load;

   logic hit;
   logic out_free;
   logic adv;
   logic scan_done;

   // A rule hits when every enabled dimension holds the point.
   always_comb begin
      hit = 1'b1;
      for (int d = 0; d < CMP_DIMS; d++) begin
         if (dim_en_ff[d] && ((pt_ff[d] < rd_low[d]) || (pt_ff[d] > rd_high[d]))) begin
            hit = 1'b0;
         end
      end
   end

   // Configuration captured at the start of a classify.
   always_comb begin
      if (32'(rules_cfg) > MAX_RULES) begin
         nrules_in = COUNT_BITS'(MAX_RULES);
      end else begin
         nrules_in = COUNT_BITS'(rules_cfg);
      end
      for (int d = 0; d < CMP_DIMS; d++) begin
         dim_en_in[d] = (32'(dims_cfg) > 32'(d));
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // The compare stage may move unless it must send the held match into a busy output.
   assign adv       = !cmp_valid_ff || !(hit && pend_valid_ff) || out_free;
   assign scan_done = (issue_ff == nrules_ff) && !cmp_valid_ff;

   // Sequencer, read issue and match bookkeeping.
   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_rule_in   = cmp_rule_ff;
      pend_valid_in = pend_valid_ff;
      pend_rule_in  = pend_rule_ff;
      multi_in      = multi_ff;
      rd_en         = 1'b0;
      rsp_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in      = ST_SCAN;
               issue_in      = '0;
               cmp_valid_in  = 1'b0;
               pend_valid_in = 1'b0;
               multi_in      = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINAL;
            end else if (adv) begin
               // Retire the rule in the compare stage.
               if (cmp_valid_ff && hit) begin
                  pend_valid_in = 1'b1;
                  pend_rule_in  = cmp_rule_ff;
                  if (pend_valid_ff) begin
                     multi_in                 = 1'b1;
                     rsp_load                 = 1'b1;
                     rsp_data_in.matched_rule = RULE_ID_BITS'(pend_rule_ff);
                     rsp_data_in.no_match     = 1'b0;
                     rsp_data_in.overlap      = 1'b1;
                     rsp_data_in.last         = 1'b0;
                  end
               end
               // Issue the next rule read.
               if (issue_ff < nrules_ff) begin
                  rd_en        = 1'b1;
                  cmp_rule_in  = issue_ff[RULE_BITS-1:0];
                  issue_in     = issue_ff + 1'b1;
                  cmp_valid_in = 1'b1;
               end else begin
                  cmp_valid_in = 1'b0;
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
               rsp_load = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in.matched_rule = RULE_ID_BITS'(pend_rule_ff);
                  rsp_data_in.no_match     = 1'b0;
                  rsp_data_in.overlap      = multi_ff;
               end else begin
                  rsp_data_in.matched_rule = '0;
                  rsp_data_in.no_match     = 1'b1;
                  rsp_data_in.overlap      = 1'b0;
               end
               rsp_data_in.last = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_rule = issue_ff[RULE_BITS-1:0];

   // Output register valid.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working registers and payload.
   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      cmp_rule_ff  <= cmp_rule_in;
      pend_rule_ff <= pend_rule_in;
      multi_ff     <= multi_in;
      rsp_data_ff  <= rsp_data_in;
      if (state_ff == ST_IDLE && start) begin
         nrules_ff <= nrules_in;
         dim_en_ff <= dim_en_in;
         for (int d = 0; d < CMP_DIMS; d++) begin
            pt_ff[d] <= FIELD_BITS'(start_points[d]);
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the multi-field range rule matcher.
// Drives bound writes and classify transactions, predicts the ordered match list
// internally, and checks every response. Depends on mfrm_pkg and the top level.
`timescale 1ns / 1ps

module tb_top;
   import mfrm_pkg::*;

   localparam int CLOCK_PERIOD         = 10;
   localparam int RESET_CYCLES         = 6;
   localparam int TABLE_RULES          = 32;
   localparam int TABLE_DIMS           = 4;
   localparam int TABLE_DEPTH          = TABLE_RULES * TABLE_DIMS;
   // A classify walks at most all rules of the table.
   localparam int SETTLE_CYCLES        = 40;
   localparam int PRESSURE_HOLD_CYCLES = 300;
   localparam int WATCHDOG_CYCLES      = 2_000_000;
   localparam int MAX_PRINTED_ERRORS   = 50;

   typedef logic [POINT_FIELDS-1:0][POINT_BITS-1:0] point_type;

   typedef struct packed {
      logic                    op;
      logic [RULE_ID_BITS-1:0] rule_index;
      logic [DIM_ID_BITS-1:0]  dim_index;
      logic [POINT_BITS-1:0]   bound_low;
      logic [POINT_BITS-1:0]   bound_high;
      point_type               point;
   } request_type;

   // Clock, reset and block inputs, all known from time zero.
   logic clock;
   logic reset = 1'b1;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_op = OP_WRITE;
   logic [RULE_ID_BITS-1:0]   req_rule_index = '0;
   logic [DIM_ID_BITS-1:0]    req_dim_index = '0;
   logic [POINT_BITS-1:0]     req_bound_low = '0;
   logic [POINT_BITS-1:0]     req_bound_high = '0;
   logic [POINT_BITS-1:0]     req_point_0 = '0;
   logic [POINT_BITS-1:0]     req_point_1 = '0;
   logic [POINT_BITS-1:0]     req_point_2 = '0;
   logic [POINT_BITS-1:0]     req_point_3 = '0;
   logic                      rsp_stall = 1'b0;

   logic                      req_stall;
   logic                      rsp_valid;
   logic [RULE_ID_BITS-1:0]   rsp_matched_rule;
   logic                      rsp_no_match;
   logic                      rsp_overlap;
   logic                      rsp_last;

   // Shadow copy of the rule table and the configuration registers.
   logic [POINT_BITS-1:0]     bound_lo [TABLE_DEPTH];
   logic [POINT_BITS-1:0]     bound_hi [TABLE_DEPTH];
   logic [RULES_CFG_BITS-1:0] cfg_rules = RULES_CFG_RESET;
   logic [DIMS_CFG_BITS-1:0]  cfg_dims = DIMS_CFG_RESET;

   rsp_type pending_matches [$];
   int      error_count = 0;
   bit      hold_req = 1'b0;
   bit      hold_active = 1'b0;

   multi_field_range_rule_match #(
      .MAX_RULES  (TABLE_RULES),
      .MAX_DIMS   (TABLE_DIMS),
      .FIELD_BITS (POINT_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_rule_index   (req_rule_index),
      .req_dim_index    (req_dim_index),
      .req_bound_low    (req_bound_low),
      .req_bound_high   (req_bound_high),
      .req_point_0      (req_point_0),
      .req_point_1      (req_point_1),
      .req_point_2      (req_point_2),
      .req_point_3      (req_point_3),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched_rule (rsp_matched_rule),
      .rsp_no_match     (rsp_no_match),
      .rsp_overlap      (rsp_overlap),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Printing stops after a while so a broken block cannot flood the log.
   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED_ERRORS) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   // Append one predicted response at the tail of the expected list.
   task automatic queue_expected(input rsp_type entry);
      pending_matches.insert(pending_matches.size(), entry);
   endtask

   // Register values above the table size saturate.
   function automatic int active_rule_count();
      return (cfg_rules > TABLE_RULES) ? TABLE_RULES : int'(cfg_rules);
   endfunction

   function automatic int active_dim_count();
      int n;
      n = int'(cfg_dims);
      if (n > TABLE_DIMS) n = TABLE_DIMS;
      if (n > POINT_FIELDS) n = POINT_FIELDS;
      return n;
   endfunction

   // A rule contains the point when each compared dimension lies in its bounds.
   function automatic bit rule_contains(input int rule, input int ndims, input point_type pt);
      int slot;
      rule_contains = 1'b1;
      for (int d = 0; d < ndims; d++) begin
         slot = rule * TABLE_DIMS + d;
         if (pt[d] < bound_lo[slot] || pt[d] > bound_hi[slot]) rule_contains = 1'b0;
      end
   endfunction

   // Queue the ordered match list for one classify, or a single no-match.
   task automatic compute_matches(input point_type pt);
      int nrules;
      int ndims;
      int hits;
      int sent;
      rsp_type entry;
      nrules = active_rule_count();
      ndims = active_dim_count();
      hits = 0;
      for (int r = 0; r < nrules; r++) begin
         if (rule_contains(r, ndims, pt)) hits++;
      end
      if (hits == 0) begin
         entry.matched_rule = '0;
         entry.no_match = 1'b1;
         entry.overlap = 1'b0;
         entry.last = 1'b1;
         queue_expected(entry);
      end else begin
         sent = 0;
         for (int r = 0; r < nrules; r++) begin
            if (rule_contains(r, ndims, pt)) begin
               sent++;
               entry.matched_rule = r[RULE_ID_BITS-1:0];
               entry.no_match = 1'b0;
               entry.overlap = (hits >= 2);
               entry.last = (sent == hits);
               queue_expected(entry);
            end
         end
      end
   endtask

   // Back-to-back half the time, sometimes short pauses, rarely long ones.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Present one request transaction and update the shadow state once it is taken.
   task automatic issue_request(input request_type item, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= item.op;
      req_rule_index <= item.rule_index;
      req_dim_index  <= item.dim_index;
      req_bound_low  <= item.bound_low;
      req_bound_high <= item.bound_high;
      req_point_0    <= item.point[0];
      req_point_1    <= item.point[1];
      req_point_2    <= item.point[2];
      req_point_3    <= item.point[3];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.op == OP_WRITE) begin
         bound_lo[int'(item.rule_index) * TABLE_DIMS + int'(item.dim_index)] = item.bound_low;
         bound_hi[int'(item.rule_index) * TABLE_DIMS + int'(item.dim_index)] = item.bound_high;
      end else begin
         compute_matches(item.point);
      end
   endtask

   // Unused fields carry random filler so every bit toggles.
   task automatic send_write(input int rule, input int dim,
                             input logic [POINT_BITS-1:0] lo, input logic [POINT_BITS-1:0] hi);
      request_type item;
      item.op = OP_WRITE;
      item.rule_index = rule[RULE_ID_BITS-1:0];
      item.dim_index = dim[DIM_ID_BITS-1:0];
      item.bound_low = lo;
      item.bound_high = hi;
      item.point = {$urandom, $urandom};
      issue_request(item, pick_gap());
   endtask

   task automatic send_classify(input point_type pt, input int gap);
      request_type item;
      item.op = OP_CLASSIFY;
      item.rule_index = RULE_ID_BITS'($urandom);
      item.dim_index = DIM_ID_BITS'($urandom);
      item.bound_low = POINT_BITS'($urandom);
      item.bound_high = POINT_BITS'($urandom);
      item.point = pt;
      issue_request(item, gap);
   endtask

   // Bound pairs: full range, ordinary, single value, inverted or pinned at an end.
   task automatic make_bounds(output logic [POINT_BITS-1:0] lo, output logic [POINT_BITS-1:0] hi);
      int p;
      int a;
      int b;
      p = $urandom_range(0, 99);
      if (p < 40) begin
         lo = '0;
         hi = '1;
      end else if (p < 75) begin
         a = $urandom_range(0, 16'hFFFF);
         b = $urandom_range(0, 16'hFFFF);
         lo = POINT_BITS'((a < b) ? a : b);
         hi = POINT_BITS'((a < b) ? b : a);
      end else if (p < 85) begin
         lo = POINT_BITS'($urandom);
         hi = lo;
      end else if (p < 95) begin
         a = $urandom_range(1, 16'hFFFF);
         b = $urandom_range(0, a - 1);
         lo = POINT_BITS'(a);
         hi = POINT_BITS'(b);
      end else begin
         lo = ($urandom_range(0, 1) == 0) ? '0 : '1;
         hi = lo;
      end
   endtask

   // Most points fall inside one active rule so that matches are common.
   task automatic make_point(output point_type pt);
      int mode;
      int target;
      int slot;
      int nrules;
      nrules = active_rule_count();
      target = (nrules > 0) ? $urandom_range(0, nrules - 1) : $urandom_range(0, TABLE_RULES - 1);
      mode = $urandom_range(0, 99);
      for (int d = 0; d < POINT_FIELDS; d++) begin
         slot = target * TABLE_DIMS + d;
         if (mode < 60 && bound_lo[slot] <= bound_hi[slot]) begin
            pt[d] = POINT_BITS'($urandom_range(bound_hi[slot], bound_lo[slot]));
         end else if (mode < 85) begin
            pt[d] = POINT_BITS'($urandom);
         end else begin
            case ($urandom_range(0, 2))
               0: pt[d] = '0;
               1: pt[d] = '1;
               default: pt[d] = POINT_BITS'($urandom);
            endcase
         end
      end
   endtask

   // Stop offering, let every response arrive, then let a trailing write retire.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == REG_RULES_IN_USE) cfg_rules = value[RULES_CFG_BITS-1:0];
      else cfg_dims = value[DIMS_CFG_BITS-1:0];
      @(posedge clock);
   endtask

   task automatic set_config(input int rules, input int dims);
      drain_block();
      write_csr(REG_RULES_IN_USE, CSR_DATA_BITS'(rules));
      write_csr(REG_DIMS_IN_USE, CSR_DATA_BITS'(dims));
   endtask

   // Every table entry is written before any classify can read it.
   task automatic test_table_load();
      logic [POINT_BITS-1:0] lo;
      logic [POINT_BITS-1:0] hi;
      for (int r = 0; r < TABLE_RULES; r++) begin
         for (int d = 0; d < TABLE_DIMS; d++) begin
            make_bounds(lo, hi);
            send_write(r, d, lo, hi);
         end
      end
   endtask

   // Classify with the register values left by reset.
   task automatic test_reset_config();
      point_type pt;
      repeat (3) begin
         make_point(pt);
         send_classify(pt, pick_gap());
      end
   endtask

   // Full-range and top-pinned rules against the all-zero and all-ones points.
   task automatic test_extreme_bounds();
      for (int d = 0; d < TABLE_DIMS; d++) send_write(0, d, '0, '1);
      for (int d = 0; d < TABLE_DIMS; d++) send_write(1, d, '1, '1);
      send_classify('0, pick_gap());
      send_classify('1, pick_gap());
   endtask

   // A rule with low above high in one dimension can never match.
   task automatic test_inverted_bounds();
      point_type pt;
      send_write(2, 1, 16'h8000, 16'h7FFF);
      for (int d = 0; d < POINT_FIELDS; d++) pt[d] = bound_lo[2 * TABLE_DIMS + d];
      pt[1] = 16'h8000;
      send_classify(pt, pick_gap());
   endtask

   // Bounds that admit a single value: hit it exactly, then miss by one.
   task automatic test_exact_point();
      point_type pt;
      pt = {$urandom, $urandom};
      for (int d = 0; d < TABLE_DIMS; d++) send_write(3, d, pt[d], pt[d]);
      send_classify(pt, pick_gap());
      pt[3] = pt[3] + 1'b1;
      send_classify(pt, pick_gap());
   endtask

   // One rule, one dimension: no match outside, single hits on both edges.
   task automatic test_single_rule();
      set_config(1, 1);
      send_write(0, 0, 16'h0010, 16'h0020);
      send_classify({48'h0, 16'h0030}, pick_gap());
      send_classify({48'h0, 16'h0010}, pick_gap());
      send_classify({48'h0, 16'h0020}, pick_gap());
      send_classify({48'h0, 16'h000F}, pick_gap());
   endtask

   // No rule takes part, so every classify is a no-match.
   task automatic test_zero_rules();
      set_config(0, 4);
      send_classify('0, pick_gap());
      send_classify('1, pick_gap());
   endtask

   // Nothing is compared, so every active rule matches.
   task automatic test_zero_dims();
      point_type pt;
      set_config(32, 0);
      make_point(pt);
      send_classify(pt, pick_gap());
   endtask

   // Register values above the table size saturate to the table size.
   task automatic test_saturated_config();
      point_type pt;
      set_config(63, 7);
      repeat (2) begin
         make_point(pt);
         send_classify(pt, pick_gap());
      end
   endtask

   // Phases of mixed bound updates and classifies under several settings.
   task automatic test_random_traffic();
      int phase_rules [8] = '{32, 16, 63, 1, 5, 32, 0, 32};
      int phase_dims  [8] = '{4, 2, 3, 4, 1, 7, 4, 0};
      int phase_items [8] = '{2, 2, 2, 2, 2, 2, 1, 1};
      point_type pt;
      logic [POINT_BITS-1:0] lo;
      logic [POINT_BITS-1:0] hi;
      for (int p = 0; p < 8; p++) begin
         set_config(phase_rules[p], phase_dims[p]);
         repeat (phase_items[p]) begin
            if ($urandom_range(0, 99) < 30) begin
               make_bounds(lo, hi);
               send_write($urandom_range(0, TABLE_RULES - 1), $urandom_range(0, TABLE_DIMS - 1),
                          lo, hi);
            end else begin
               make_point(pt);
               send_classify(pt, pick_gap());
            end
         end
      end
   endtask

   // The receiver holds off for a long stretch while classifies keep coming.
   task automatic test_output_backpressure();
      point_type pt;
      set_config(32, 4);
      hold_req = 1'b1;
      while (!hold_active) @(posedge clock);
      repeat (6) begin
         make_point(pt);
         send_classify(pt, 0);
      end
   endtask

   // Receiver stall pattern, with a long hold when the pressure test asks.
   initial begin : rsp_backpressure
      int pick;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (PRESSURE_HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 30)) @(posedge clock);
            end else if (pick < 92) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(15, 50)) @(posedge clock);
            end
         end
      end
   end

   // Each accepted response transaction is checked against the oldest prediction.
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_matches.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending: rule %0d", rsp_matched_rule));
         end else begin
            want = pending_matches.pop_front();
            if (rsp_matched_rule !== want.matched_rule)
               report_mismatch($sformatf("matched_rule got %0d want %0d",
                                         rsp_matched_rule, want.matched_rule));
            if (rsp_no_match !== want.no_match)
               report_mismatch($sformatf("no_match got %b want %b", rsp_no_match, want.no_match));
            if (rsp_overlap !== want.overlap)
               report_mismatch($sformatf("overlap got %b want %b", rsp_overlap, want.overlap));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last got %b want %b", rsp_last, want.last));
         end
      end
   end

   initial begin : watchdog
      #(WATCHDOG_CYCLES * CLOCK_PERIOD);
      $display("Some tests failed");
      $finish;
   end

   initial begin : test_sequence
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_table_load();
      test_reset_config();
      test_extreme_bounds();
      test_inverted_bounds();
      test_exact_point();
      test_single_rule();
      test_zero_rules();
      test_zero_dims();
      test_saturated_config();
      test_random_traffic();
      test_output_backpressure();
      drain_block();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
